[rtl/utf8_stream_decoder_top_defines.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Depends on nothing; files that assert include it by name.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Checks an implication on every rising edge of clk outside reset.
`define UTF8D_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition that must never be seen on a rising edge of clk.
`define UTF8D_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/utf8d_pkg.sv]
// Types and constants for the UTF-8 stream decoder.
// Used by utf8d_core and utf8_stream_decoder_top; depends on nothing.
package utf8d_pkg;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_t;

  // Result transfer payload.
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic        run_last;
  } out_t;

  // Results caused by one byte: all but the last are errors with a zero
  // code point, so a count and the last result describe the whole group.
  typedef struct packed {
    logic [2:0]  cnt;
    logic [20:0] cp;
    logic        err;
  } grp_t;

  // Sequence length codes.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Code point limits.
  localparam logic [20:0] CP_MIN2   = 21'h00080;
  localparam logic [20:0] CP_MIN3   = 21'h00800;
  localparam logic [20:0] CP_MIN4   = 21'h10000;
  localparam logic [20:0] SURR_LO   = 21'h0D800;
  localparam logic [20:0] SURR_HI   = 21'h0DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  // Most results one byte can cause.
  localparam logic [2:0] GRP_MAX = 3'd4;

endpackage

[rtl/utf8d_core.sv]
// Sequence state and decode logic of the UTF-8 stream decoder.
// Depends on utf8d_pkg; instantiated by utf8_stream_decoder_top.
module utf8d_core
  import utf8d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  in_t  item,
  output grp_t grp
);

  logic [2:0]  seq_len_r, seq_len_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [20:0] part_r, part_nxt;

  logic [7:0]  b;
  logic        last;
  logic        as_lead;
  logic        bad;
  logic [1:0]  held_inc;
  logic [2:0]  have;
  logic [20:0] acc;

  assign b    = item.data_byte;
  assign last = item.stream_end;
  assign held_inc = held_r + 2'd1;
  assign have     = {1'b0, held_inc} + 3'd1;
  assign acc      = {part_r[14:0], b[5:0]};

  // A completed value is rejected when overlong, a surrogate or too large.
  always_comb begin
    bad = 1'b0;
    if (seq_len_r == SEQ_LEN2 && acc < CP_MIN2) bad = 1'b1;
    if (seq_len_r == SEQ_LEN3 && acc < CP_MIN3) bad = 1'b1;
    if (seq_len_r == SEQ_LEN4 && acc < CP_MIN4) bad = 1'b1;
    if (acc >= SURR_LO && acc <= SURR_HI) bad = 1'b1;
    if (acc > CP_MAX) bad = 1'b1;
  end

  // Next state and result group for the byte on the input.
  always_comb begin
    seq_len_nxt = seq_len_r;
    held_nxt    = held_r;
    part_nxt    = part_r;
    grp         = '0;
    as_lead     = 1'b1;

    if (seq_len_r != SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        as_lead = 1'b0;
        if (have >= seq_len_r) begin
          // Sequence complete: one result, valid or an error.
          grp.cnt     = 3'd1;
          grp.cp      = bad ? '0 : acc;
          grp.err     = bad;
          seq_len_nxt = SEQ_NONE;
          held_nxt    = '0;
          part_nxt    = '0;
        end else if (last) begin
          // Truncated at the end of the stream: flush the lead, held bytes and this byte.
          grp.cnt     = have;
          grp.err     = 1'b1;
          seq_len_nxt = SEQ_NONE;
          held_nxt    = '0;
          part_nxt    = '0;
        end else begin
          held_nxt = held_inc;
          part_nxt = acc;
        end
      end else begin
        // Broken sequence: flush, then take this byte as a lead.
        grp.cnt     = {1'b0, held_r} + 3'd1;
        grp.err     = 1'b1;
        seq_len_nxt = SEQ_NONE;
        held_nxt    = '0;
        part_nxt    = '0;
      end
    end

    if (as_lead) begin
      if (b inside {[8'h00:8'h7F]}) begin
        grp.cnt = grp.cnt + 3'd1;
        grp.cp  = {13'd0, b};
        grp.err = 1'b0;
      end else if (!last && b inside {[8'hC0:8'hDF]}) begin
        seq_len_nxt = SEQ_LEN2;
        held_nxt    = '0;
        part_nxt    = {16'd0, b[4:0]};
      end else if (!last && b inside {[8'hE0:8'hEF]}) begin
        seq_len_nxt = SEQ_LEN3;
        held_nxt    = '0;
        part_nxt    = {17'd0, b[3:0]};
      end else if (!last && b inside {[8'hF0:8'hF7]}) begin
        seq_len_nxt = SEQ_LEN4;
        held_nxt    = '0;
        part_nxt    = {18'd0, b[2:0]};
      end else begin
        // Invalid lead, or a lead that arrives as the final byte.
        grp.cnt = grp.cnt + 3'd1;
        grp.cp  = '0;
        grp.err = 1'b1;
      end
    end
  end

  // Sequence state advances only when a byte is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= SEQ_NONE;
      held_r    <= '0;
      part_r    <= '0;
    end else if (take) begin
      seq_len_r <= seq_len_nxt;
      held_r    <= held_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

[rtl/utf8_stream_decoder_top.sv]
// Top level of the validating UTF-8 stream decoder.
// Depends on utf8d_pkg, utf8d_core and utf8_stream_decoder_top_defines.svh.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one byte a transfer with
//   a stream_end flag on the final byte of a stream. Result channel
//   out_valid/out_stall/out_data carries one code point or error marker a
//   transfer; run_last marks the final result caused by an input byte.
//   A byte that only opens or extends a sequence causes no result.
//   The first result of a byte is shown once it has passed the group
//   register, then the output register.
//   Throughput: one byte a cycle while the receiver does not stall and each
//   byte causes at most one result. A byte that causes n results holds the
//   input until all but its last result are sent, since the output register
//   sends one result a cycle; up to four results follow a broken four-byte
//   sequence. When the receiver stalls, the output register holds its result;
//   the group register still takes bytes while empty, then in_stall rises.
//   Reset clears the pending sequence and empties both registers; no
//   result is shown until new bytes arrive.
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top
  import utf8d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  grp_t        core_grp;
  logic        take;
  logic        out_load;
  logic        grp_pop_last;

  logic [2:0]  grp_cnt_r;
  logic [20:0] grp_cp_r;
  logic        grp_err_r;
  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;

  // Decode core holding the partial sequence.
  utf8d_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .grp   (core_grp)
  );

  // Handshake: the group register takes a byte when empty or when its last result loads.
  assign out_load     = !out_valid_r || !out_stall;
  assign grp_pop_last = out_load && (grp_cnt_r == 3'd1);
  assign in_stall     = (grp_cnt_r != 3'd0) && !grp_pop_last;
  assign take         = in_valid && !in_stall;

  // Next result: leading results are errors, the last carries the group.
  always_comb begin
    out_data_nxt.run_last   = (grp_cnt_r == 3'd1);
    out_data_nxt.code_point = (grp_cnt_r == 3'd1) ? grp_cp_r : '0;
    out_data_nxt.is_error   = (grp_cnt_r == 3'd1) ? grp_err_r : 1'b1;
  end

  // Control registers for the group count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= (grp_cnt_r != 3'd0);
        if (grp_cnt_r != 3'd0) begin
          grp_cnt_r <= grp_cnt_r - 3'd1;
        end
      end
      if (take) begin
        grp_cnt_r <= core_grp.cnt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_load && grp_cnt_r != 3'd0) begin
      out_data_r <= out_data_nxt;
    end
    if (take) begin
      grp_cp_r  <= core_grp.cp;
      grp_err_r <= core_grp.err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A group never holds more results than one byte can cause.
  `UTF8D_ASSERT_NEVER(a_grp_cnt_max, grp_cnt_r > GRP_MAX, "group count above four")
  // Only the last result of a byte can be a valid code point.
  `UTF8D_ASSERT_IMPL(a_lead_err, out_valid && !out_data.run_last, out_data.is_error,
    "non-final result is not an error")
  // An error result carries a zero code point.
  `UTF8D_ASSERT_IMPL(a_err_zero, out_valid && out_data.is_error, out_data.code_point == '0,
    "error result with non-zero code point")
  // Valid code points stay within the Unicode range.
  `UTF8D_ASSERT_IMPL(a_cp_range, out_valid, out_data.code_point <= CP_MAX,
    "code point above 10FFFF")
  // The input stalls only while results of an earlier byte remain.
  `UTF8D_ASSERT_IMPL(a_stall_cause, in_stall, grp_cnt_r != 3'd0,
    "input stalled with an empty group register")

endmodule
